// File: rtl/bssr_pkg.sv
// Shared constants, register codes and configuration type of the brush stamp span rasterizer.
package bssr_pkg;

	localparam int unsigned MAX_DIM   = 2048;
	localparam int unsigned MAX_BRUSH = 64;

	localparam int unsigned COORD_W = 11;
	localparam int unsigned DIM_W   = 12;
	localparam int unsigned SIZE_W  = 7;
	localparam int unsigned HALF_W  = 6;
	localparam int unsigned HSQ_W   = 11;
	localparam int unsigned ROOT_W  = 6;
	localparam int unsigned BIT_W   = 3;
	localparam int unsigned ADDR_W  = 24;
	localparam int unsigned MUL_W   = 12;
	localparam int unsigned PROD_W  = 24;
	localparam int unsigned COLOR_W = 8;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned DATA_W  = 12;

	typedef enum logic [IDX_W-1:0] {
		REG_CANVAS_WIDTH  = 3'd0,
		REG_CANVAS_HEIGHT = 3'd1,
		REG_ROUND_SHAPE   = 3'd2,
		REG_BRUSH_SIZE    = 3'd3,
		REG_COLOR_RED     = 3'd4,
		REG_COLOR_GREEN   = 3'd5,
		REG_COLOR_BLUE    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [DIM_W-1:0]   canvas_width;
		logic [DIM_W-1:0]   canvas_height;
		logic               round_shape;
		logic [SIZE_W-1:0]  brush_size;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} cfg_t;

endpackage

// File: rtl/bssr_ifs.sv
// Valid/ready channel interfaces for brush centres and emitted row spans.
interface bssr_in_if import bssr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] centre_x;
	logic [COORD_W-1:0] centre_y;

	modport source(output valid, centre_x, centre_y, input ready);
	modport sink(input valid, centre_x, centre_y, output ready);
endinterface

interface bssr_out_if import bssr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] span_row;
	logic [COORD_W-1:0] span_first;
	logic [COORD_W-1:0] span_last;
	logic               span_empty;
	logic [ADDR_W-1:0]  start_address;
	logic [COLOR_W-1:0] out_red;
	logic [COLOR_W-1:0] out_green;
	logic [COLOR_W-1:0] out_blue;
	logic               last_span;

	modport source(output valid, span_row, span_first, span_last, span_empty, start_address,
		out_red, out_green, out_blue, last_span, input ready);
	modport sink(input valid, span_row, span_first, span_last, span_empty, start_address,
		out_red, out_green, out_blue, last_span, output ready);
endinterface

// File: rtl/bssr_mul.sv
// Shared unsigned multiplier with a registered product.
module bssr_mul import bssr_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(a * b);
		end
	end

endmodule

// File: rtl/bssr_core.sv
// Stamp sequencer: box clamping, per-row disc root search and span output register.
module bssr_core import bssr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	bssr_in_if.sink    centre,
	bssr_out_if.source span
);

	typedef logic signed [COORD_W+1:0] scoord_t;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_SETUP = 10'b0000000010,
		S_HSQ   = 10'b0000000100,
		S_START = 10'b0000001000,
		S_REM   = 10'b0000010000,
		S_TRY   = 10'b0000100000,
		S_CHK   = 10'b0001000000,
		S_SPAN  = 10'b0010000000,
		S_ADDR  = 10'b0100000000,
		S_EMIT  = 10'b1000000000
	} state_t;

	state_t             state_q;
	logic [COORD_W-1:0] x_q, y_q, left_q, right_q, bot_q, row_q, first_q, last_q;
	logic               empty_q, off_q, round_q;
	logic [HALF_W-1:0]  h_q;
	logic [HSQ_W-1:0]   hsq_q, rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [BIT_W-1:0]   bit_q;

	logic               ov_q;
	logic [COORD_W-1:0] o_row_q, o_first_q, o_last_q;
	logic               o_empty_q, o_last_span_q;
	logic [ADDR_W-1:0]  o_addr_q;
	logic [COLOR_W-1:0] o_red_q, o_green_q, o_blue_q;

	logic [DIM_W-1:0]   w_sat, h_sat;
	logic [SIZE_W-1:0]  s_sat;
	logic [HALF_W-1:0]  half;
	logic               size1;
	logic [COORD_W-1:0] wm1, hm1;
	scoord_t            xs, ys, hs, dy, lo, hi, fs, ls;
	logic [COORD_W-1:0] ady;
	logic [ROOT_W-1:0]  trial;
	logic [PROD_W-1:0]  prod;
	logic               mul_en, out_free;
	logic [MUL_W-1:0]   mul_a, mul_b;
	logic [ADDR_W-1:0]  sum, addr;

	function automatic logic [COORD_W-1:0] clamp(scoord_t v, logic [COORD_W-1:0] top);
		logic [COORD_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > scoord_t'({2'b00, top})) begin
			r = top;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	always_comb begin
		if (cfg.canvas_width == '0) begin
			w_sat = DIM_W'(1);
		end else if (cfg.canvas_width > DIM_W'(MAX_DIM)) begin
			w_sat = DIM_W'(MAX_DIM);
		end else begin
			w_sat = cfg.canvas_width;
		end
		if (cfg.canvas_height == '0) begin
			h_sat = DIM_W'(1);
		end else if (cfg.canvas_height > DIM_W'(MAX_DIM)) begin
			h_sat = DIM_W'(MAX_DIM);
		end else begin
			h_sat = cfg.canvas_height;
		end
		if (cfg.brush_size == '0) begin
			s_sat = SIZE_W'(1);
		end else if (cfg.brush_size > SIZE_W'(MAX_BRUSH)) begin
			s_sat = SIZE_W'(MAX_BRUSH);
		end else begin
			s_sat = cfg.brush_size;
		end
	end

	assign half  = HALF_W'(s_sat >> 1);
	assign size1 = (s_sat == SIZE_W'(1));
	assign wm1   = COORD_W'(w_sat - DIM_W'(1));
	assign hm1   = COORD_W'(h_sat - DIM_W'(1));

	assign xs = scoord_t'({2'b00, x_q});
	assign ys = scoord_t'({2'b00, y_q});
	assign hs = scoord_t'({{(COORD_W+2-HALF_W){1'b0}}, half});
	assign dy = scoord_t'({2'b00, row_q}) - ys;
	assign ady = (dy < 0) ? COORD_W'(-dy) : dy[COORD_W-1:0];

	assign trial = root_q | (ROOT_W'(1) << bit_q);
	assign lo = xs - scoord_t'({{(COORD_W+2-ROOT_W){1'b0}}, root_q});
	assign hi = xs + scoord_t'({{(COORD_W+2-ROOT_W){1'b0}}, root_q});
	assign fs = (lo > scoord_t'({2'b00, left_q})) ? lo : scoord_t'({2'b00, left_q});
	assign ls = (hi < scoord_t'({2'b00, right_q})) ? hi : scoord_t'({2'b00, right_q});

	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			S_SETUP: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(half);
				mul_b  = MUL_W'(half);
			end
			S_START: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(ady);
				mul_b  = MUL_W'(ady);
			end
			S_TRY: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(trial);
				mul_b  = MUL_W'(trial);
			end
			S_ADDR: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(row_q);
				mul_b  = w_sat;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	bssr_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	// Byte address is three bytes per pixel, formed as sum plus twice sum.
	assign sum  = prod + ADDR_W'(first_q);
	assign addr = sum + (sum << 1);

	assign out_free     = !ov_q || span.ready;
	assign centre.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			ov_q <= (ov_q && !span.ready) || ((state_q == S_EMIT) && out_free);
			case (state_q)
				S_IDLE: begin
					if (centre.valid) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: state_q <= S_HSQ;
				S_HSQ:   state_q <= S_START;
				S_START: begin
					if (!round_q) begin
						state_q <= off_q ? S_EMIT : S_ADDR;
					end else if (ady > COORD_W'(h_q)) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_REM;
					end
				end
				S_REM: state_q <= S_TRY;
				S_TRY: state_q <= S_CHK;
				S_CHK: begin
					state_q <= (bit_q == '0) ? S_SPAN : S_TRY;
				end
				S_SPAN: begin
					state_q <= (fs > ls) ? S_EMIT : S_ADDR;
				end
				S_ADDR: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						state_q <= (row_q == bot_q) ? S_IDLE : S_START;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q <= centre.centre_x;
				y_q <= centre.centre_y;
			end
			S_SETUP: begin
				h_q     <= half;
				round_q <= cfg.round_shape && !size1;
				if (size1) begin
					left_q  <= x_q;
					right_q <= x_q;
					bot_q   <= y_q;
					row_q   <= y_q;
					off_q   <= !((DIM_W'(x_q) < w_sat) && (DIM_W'(y_q) < h_sat));
				end else begin
					left_q  <= clamp(xs - hs, wm1);
					right_q <= clamp(xs + hs - scoord_t'(1), wm1);
					bot_q   <= clamp(ys + hs - scoord_t'(1), hm1);
					row_q   <= clamp(ys - hs, hm1);
					off_q   <= 1'b0;
				end
			end
			S_HSQ: hsq_q <= prod[HSQ_W-1:0];
			S_START: begin
				if (!round_q) begin
					first_q <= left_q;
					last_q  <= right_q;
					empty_q <= off_q;
				end else begin
					first_q <= '0;
					last_q  <= '0;
					empty_q <= 1'b1;
				end
			end
			S_REM: begin
				rem_q  <= hsq_q - prod[HSQ_W-1:0];
				root_q <= '0;
				bit_q  <= BIT_W'(ROOT_W - 1);
			end
			S_CHK: begin
				if (prod <= PROD_W'(rem_q)) begin
					root_q <= trial;
				end
				bit_q <= bit_q - BIT_W'(1);
			end
			S_SPAN: begin
				if (fs <= ls) begin
					first_q <= fs[COORD_W-1:0];
					last_q  <= ls[COORD_W-1:0];
					empty_q <= 1'b0;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					o_row_q       <= off_q ? '0 : row_q;
					o_first_q     <= empty_q ? '0 : first_q;
					o_last_q      <= empty_q ? '0 : last_q;
					o_empty_q     <= empty_q;
					o_addr_q      <= empty_q ? '0 : addr;
					o_red_q       <= cfg.red;
					o_green_q     <= cfg.green;
					o_blue_q      <= cfg.blue;
					o_last_span_q <= (row_q == bot_q);
					row_q         <= row_q + COORD_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign span.valid         = ov_q;
	assign span.span_row      = o_row_q;
	assign span.span_first    = o_first_q;
	assign span.span_last     = o_last_q;
	assign span.span_empty    = o_empty_q;
	assign span.start_address = o_addr_q;
	assign span.out_red       = o_red_q;
	assign span.out_green     = o_green_q;
	assign span.out_blue      = o_blue_q;
	assign span.last_span     = o_last_span_q;

endmodule

// File: rtl/brush_stamp_span_raster.sv
// Brush stamp span rasterizer: one brush centre word in, one span word per covered row out.
// A centre is taken in IDLE; in square mode it passes SETUP, HSQ, START and, unless off the canvas,
// ADDR to EMIT, which registers its first span word. A square row passes START, ADDR and EMIT; a
// round row passes START, REM, six TRY and CHK root trials on the shared multiplier, SPAN, ADDR
// and EMIT; rows that miss the disc end early. A new centre is taken only back in IDLE.
// Reset (arst_n low) idles the sequencer, empties the output register and loads register defaults.
module brush_stamp_span_raster import bssr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	bssr_in_if.sink           centre,
	bssr_out_if.source        span
);

	// Configuration registers. The user writes them only while the stamp sequencer is idle, as the
	// core reads them live; the block does not enforce it. An index past the last register is dropped.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.canvas_width  <= DIM_W'(MAX_DIM);
			cfg_q.canvas_height <= DIM_W'(MAX_DIM);
			cfg_q.round_shape   <= 1'b0;
			cfg_q.brush_size    <= SIZE_W'(1);
			cfg_q.red           <= '0;
			cfg_q.green         <= '0;
			cfg_q.blue          <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CANVAS_WIDTH:  cfg_q.canvas_width  <= cfg_data[DIM_W-1:0];
				REG_CANVAS_HEIGHT: cfg_q.canvas_height <= cfg_data[DIM_W-1:0];
				REG_ROUND_SHAPE:   cfg_q.round_shape   <= cfg_data[0];
				REG_BRUSH_SIZE:    cfg_q.brush_size    <= cfg_data[SIZE_W-1:0];
				REG_COLOR_RED:     cfg_q.red           <= cfg_data[COLOR_W-1:0];
				REG_COLOR_GREEN:   cfg_q.green         <= cfg_data[COLOR_W-1:0];
				REG_COLOR_BLUE:    cfg_q.blue          <= cfg_data[COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The core clamps the box to the canvas, walks its rows top to bottom and, for
	// the round brush, finds the half chord of each row as an integer square root
	// built one bit at a time on the shared multiplier. The chord is then cut by the
	// clamped box, which yields the first and last painted column or an empty row.
	bssr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.centre (centre),
		.span   (span)
	);

endmodule

// File: test/testbench.sv
// Self-checking testbench of the brush stamp span rasterizer: directed and random centres.
module testbench;
	import bssr_pkg::*;

	// The write to this index hits no register, and the block must ignore it.
	localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

	// Words keep moving inside even a stamp of 64 round rows.
	// The longest stretch without any handshake is the receiver hold-off plus one row.
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_ITEMS   = 20;

	// One output word, one field for each field of the span channel.
	typedef struct {
		logic [COORD_W-1:0] span_row;
		logic [COORD_W-1:0] span_first;
		logic [COORD_W-1:0] span_last;
		logic               span_empty;
		logic [ADDR_W-1:0]  start_address;
		logic [COLOR_W-1:0] out_red;
		logic [COLOR_W-1:0] out_green;
		logic [COLOR_W-1:0] out_blue;
		logic               last_span;
	} span_word_t;

	// The ledger keeps its own copy of the registers, turns every accepted centre into the
	// spans the stamp must produce and checks the words leaving the block against them in
	// order.
	class span_ledger;
		cfg_t       cfg;
		span_word_t due_spans[$];

		function new();
			cfg.canvas_width  = DIM_W'(MAX_DIM);
			cfg.canvas_height = DIM_W'(MAX_DIM);
			cfg.round_shape   = 1'b0;
			cfg.brush_size    = SIZE_W'(1);
			cfg.red           = '0;
			cfg.green         = '0;
			cfg.blue          = '0;
		endfunction

		// A zero dimension counts as one pixel; anything above the maximum is saturated.
		function int eff_dim(logic [DIM_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > MAX_DIM)
				return MAX_DIM;
			return int'(v);
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] d);
			case (idx)
				REG_CANVAS_WIDTH:  cfg.canvas_width  = d;
				REG_CANVAS_HEIGHT: cfg.canvas_height = d;
				REG_ROUND_SHAPE:   cfg.round_shape   = d[0];
				REG_BRUSH_SIZE:    cfg.brush_size    = d[SIZE_W-1:0];
				REG_COLOR_RED:     cfg.red           = d[COLOR_W-1:0];
				REG_COLOR_GREEN:   cfg.green         = d[COLOR_W-1:0];
				REG_COLOR_BLUE:    cfg.blue          = d[COLOR_W-1:0];
				default: ;
			endcase
		endfunction

		function void push_span(int row, int first, int last, bit blank, int w, bit fin);
			span_word_t s;
			int         addr;
			addr            = blank ? 0 : (first + row * w) * 3;
			s.span_row      = row[COORD_W-1:0];
			s.span_first    = blank ? '0 : first[COORD_W-1:0];
			s.span_last     = blank ? '0 : last[COORD_W-1:0];
			s.span_empty    = blank;
			s.start_address = addr[ADDR_W-1:0];
			s.out_red       = cfg.red;
			s.out_green     = cfg.green;
			s.out_blue      = cfg.blue;
			s.last_span     = fin;
			due_spans.push_back(s);
		endfunction

		function int clamp(int v, int lo, int hi);
			if (v < lo)
				return lo;
			if (v > hi)
				return hi;
			return v;
		endfunction

		// Works out the spans of one stamp, top row first.
		function void take_centre(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
			int x, y, w, hg, s, h, left, right, top, bot, row, first, last, dy, dx, c;
			bit blank;
			x  = int'(cx);
			y  = int'(cy);
			w  = eff_dim(cfg.canvas_width);
			hg = eff_dim(cfg.canvas_height);
			s  = int'(cfg.brush_size);
			if (s < 1)
				s = 1;
			if (s > MAX_BRUSH)
				s = MAX_BRUSH;
			if (s == 1) begin
				// A single pixel; off the canvas it still yields one empty span.
				if (x < w && y < hg)
					push_span(y, x, x, 1'b0, w, 1'b1);
				else
					push_span(0, 0, 0, 1'b1, w, 1'b1);
				return;
			end
			h     = s / 2;
			left  = clamp(x - h, 0, w - 1);
			right = clamp(x + h - 1, 0, w - 1);
			top   = clamp(y - h, 0, hg - 1);
			bot   = clamp(y + h - 1, 0, hg - 1);
			for (row = top; row <= bot; row++) begin
				first = left;
				last  = right;
				blank = 1'b0;
				if (cfg.round_shape) begin
					dy    = row - y;
					first = -1;
					last  = -1;
					for (c = left; c <= right; c++) begin
						dx = c - x;
						if (dx * dx + dy * dy <= h * h) begin
							if (first < 0)
								first = c;
							last = c;
						end
					end
					if (first < 0) begin
						blank = 1'b1;
						first = 0;
						last  = 0;
					end
				end
				push_span(row, first, last, blank, w, row == bot);
			end
		endfunction

		// Returns an empty string when the word matches the oldest expected span.
		function string match_span(span_word_t got);
			span_word_t want;
			string      msg;
			if (due_spans.size() == 0)
				return $sformatf("span word for row %0d with nothing expected", got.span_row);
			want = due_spans.pop_front();
			msg  = "";
			if (got.span_row !== want.span_row)
				msg = {msg, $sformatf(" span_row %0d/%0d", got.span_row, want.span_row)};
			if (got.span_first !== want.span_first)
				msg = {msg, $sformatf(" span_first %0d/%0d", got.span_first, want.span_first)};
			if (got.span_last !== want.span_last)
				msg = {msg, $sformatf(" span_last %0d/%0d", got.span_last, want.span_last)};
			if (got.span_empty !== want.span_empty)
				msg = {msg, $sformatf(" span_empty %0b/%0b", got.span_empty, want.span_empty)};
			if (got.start_address !== want.start_address)
				msg = {msg, $sformatf(" start_address %0d/%0d", got.start_address,
					want.start_address)};
			if (got.out_red !== want.out_red)
				msg = {msg, $sformatf(" out_red %0d/%0d", got.out_red, want.out_red)};
			if (got.out_green !== want.out_green)
				msg = {msg, $sformatf(" out_green %0d/%0d", got.out_green, want.out_green)};
			if (got.out_blue !== want.out_blue)
				msg = {msg, $sformatf(" out_blue %0d/%0d", got.out_blue, want.out_blue)};
			if (got.last_span !== want.last_span)
				msg = {msg, $sformatf(" last_span %0b/%0b", got.last_span, want.last_span)};
			if (msg != "")
				msg = {$sformatf("row %0d got/expected:", want.span_row), msg};
			return msg;
		endfunction

		function int pending();
			return due_spans.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	logic [DATA_W-1:0] cfg_data;

	bssr_in_if  cen();
	bssr_out_if spn();

	span_ledger ledger;
	int         failures = 0;

	// The main sequence sets these; the receiver reads them at its own edges.
	bit hold_req = 1'b0;
	bit calm     = 1'b0;

	brush_stamp_span_raster uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.centre    (cen),
		.span      (spn)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Each mismatch counts; printing stops after a hundred to keep the log short.
	task automatic report(input string msg);
		if (failures < 100)
			$display("MISMATCH at %0t: %s", $time, msg);
		failures++;
	endtask

	// Drives one register write and lets it land at the next edge. The caller lowers the
	// write enable after its last write, so the enable never drops and rises in one step.
	task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		ledger.set_reg(idx, d);
	endtask

	// Loads a whole setting, including one write to the unused index, which must not
	// disturb anything.
	task automatic load_setup(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] hg,
		input logic rnd, input logic [SIZE_W-1:0] sz, input logic [COLOR_W-1:0] r,
		input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
		put_reg(REG_CANVAS_WIDTH, w);
		put_reg(REG_CANVAS_HEIGHT, hg);
		put_reg(REG_ROUND_SHAPE, DATA_W'(rnd));
		put_reg(REG_BRUSH_SIZE, DATA_W'(sz));
		put_reg(REG_COLOR_RED, DATA_W'(r));
		put_reg(REG_COLOR_GREEN, DATA_W'(g));
		put_reg(REG_COLOR_BLUE, DATA_W'(b));
		put_reg(REG_NONE, DATA_W'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one centre word, with random gaps in front of it unless the calm stretch is on,
	// and hands it to the ledger at the edge where it is taken.
	task automatic offer_centre(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		while (!calm && $urandom_range(99) < 24) begin
			cen.valid <= 1'b0;
			@(posedge clk);
		end
		cen.valid    <= 1'b1;
		cen.centre_x <= x;
		cen.centre_y <= y;
		do begin
			@(posedge clk);
		end while (!cen.ready);
		ledger.take_centre(x, y);
	endtask

	// Stops offering, waits for every expected span, then lets the sequencer drop back to idle
	// before any register changes.
	task automatic settle();
		cen.valid <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random canvas dimension: mostly small so that clamping happens often, sometimes an
	// extreme that saturates or collapses to one pixel.
	function automatic logic [DIM_W-1:0] pick_dim();
		if ($urandom_range(99) < 15) begin
			case ($urandom_range(3))
				0: return DIM_W'(0);
				1: return DIM_W'(1);
				2: return DIM_W'(MAX_DIM);
				default: return {DIM_W{1'b1}};
			endcase
		end
		return DIM_W'($urandom_range(48, 1));
	endfunction

	// Random brush: mostly small sizes, since a large round stamp is slow.
	function automatic logic [SIZE_W-1:0] pick_size();
		if ($urandom_range(99) < 10) begin
			case ($urandom_range(2))
				0: return SIZE_W'(0);
				1: return SIZE_W'(MAX_BRUSH);
				default: return {SIZE_W{1'b1}};
			endcase
		end
		return SIZE_W'($urandom_range(12, 1));
	endfunction

	// Receiver: checks every word taken and throttles ready. Once the main sequence asks for
	// it, ready stays low for a long count so that the block fills and stalls its input.
	initial begin
		span_word_t got;
		string      msg;
		int         hold_left;
		bit         hold_taken;
		hold_left  = 0;
		hold_taken = 1'b0;
		spn.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && spn.valid && spn.ready) begin
				got.span_row      = spn.span_row;
				got.span_first    = spn.span_first;
				got.span_last     = spn.span_last;
				got.span_empty    = spn.span_empty;
				got.start_address = spn.start_address;
				got.out_red       = spn.out_red;
				got.out_green     = spn.out_green;
				got.out_blue      = spn.out_blue;
				got.last_span     = spn.last_span;
				msg = ledger.match_span(got);
				if (msg != "")
					report(msg);
			end
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				spn.ready <= 1'b0;
			end else if (calm) begin
				spn.ready <= 1'b1;
			end else begin
				spn.ready <= ($urandom_range(99) >= 24);
			end
		end
	end

	// Watchdog: ends the run when no word has moved on either channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cen.valid && cen.ready) || (spn.valid && spn.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Main sequence: reset, directed settings, then random settings with random centres.
	initial begin
		logic [COORD_W-1:0] x, y;
		int                 lim_x, lim_y;
		ledger        = new();
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		cen.valid    <= 1'b0;
		cen.centre_x <= '0;
		cen.centre_y <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: full canvas, size one. Single pixels at the corners and inside.
		offer_centre(11'd0, 11'd0);
		offer_centre(11'd2047, 11'd2047);
		offer_centre(11'd1024, 11'd5);
		settle();

		// Width zero acts as one column, height above the maximum saturates and size zero
		// acts as size one; the round flag has no effect on a single pixel. A centre right
		// of the one column is off the canvas and must give one empty span.
		load_setup(12'd0, 12'd4095, 1'b1, 7'd0, 8'd255, 8'd255, 8'd255);
		offer_centre(11'd0, 11'd0);
		offer_centre(11'd1, 11'd0);
		offer_centre(11'd0, 11'd2047);
		offer_centre(11'd2047, 11'd3);
		settle();

		// An oversized brush saturates to the largest size and is clamped hard on a small
		// canvas. A far centre leaves the whole box off the canvas, so it sticks to the
		// corner pixel.
		load_setup(12'd16, 12'd12, 1'b0, 7'd127, 8'h5A, 8'hA5, 8'h0F);
		offer_centre(11'd8, 11'd6);
		offer_centre(11'd2047, 11'd2047);
		offer_centre(11'd0, 11'd0);
		settle();

		// Largest round disc on the full canvas: centre, top-left corner, bottom-right.
		load_setup(12'd2048, 12'd2048, 1'b1, 7'd64, 8'd1, 8'd128, 8'd254);
		offer_centre(11'd1024, 11'd1024);
		offer_centre(11'd0, 11'd0);
		offer_centre(11'd2047, 11'd2047);
		settle();

		// Odd round size, one pixel short of symmetric. A centre far right of the canvas
		// clamps to the edge column, which lies outside the disc, so every row is empty.
		load_setup(12'd20, 12'd20, 1'b1, 7'd7, 8'd200, 8'd0, 8'd77);
		offer_centre(11'd10, 11'd10);
		offer_centre(11'd40, 11'd3);
		offer_centre(11'd19, 11'd19);
		offer_centre(11'd0, 11'd10);
		settle();

		// Smallest box on a one-pixel canvas.
		load_setup(12'd1, 12'd1, 1'b0, 7'd2, 8'd0, 8'd0, 8'd0);
		offer_centre(11'd0, 11'd0);
		offer_centre(11'd2047, 11'd2047);
		settle();

		// Random part. Most centres land on or just beyond the canvas so the stamp does real
		// work; the rest cover the whole coordinate range. The second phase carries the long
		// receiver hold-off and the fourth runs with no idling on either side.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			load_setup(pick_dim(), pick_dim(), 1'($urandom_range(1)), pick_size(),
				8'($urandom), 8'($urandom), 8'($urandom));
			if (p == 1)
				hold_req <= 1'b1;
			calm <= (p == 3);
			lim_x = ledger.eff_dim(ledger.cfg.canvas_width) + 8;
			lim_y = ledger.eff_dim(ledger.cfg.canvas_height) + 8;
			if (lim_x > 2047)
				lim_x = 2047;
			if (lim_y > 2047)
				lim_y = 2047;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(99) < 80) begin
					x = COORD_W'($urandom_range(lim_x, 0));
					y = COORD_W'($urandom_range(lim_y, 0));
				end else begin
					x = COORD_W'($urandom_range(2047, 0));
					y = COORD_W'($urandom_range(2047, 0));
				end
				offer_centre(x, y);
			end
			settle();
		end

		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
